/* rtl/fvcc_pkg.sv */
package fvcc_pkg;

  localparam int FLOW_FRAC_BITS_DEF = 12;
  localparam int CORDIC_STAGES_DEF  = 16;
  localparam int CORDIC_MAX_STAGES  = 24;

  // CORDIC datapath widths: operands carry 8 guard bits plus gain growth
  localparam int GUARD_BITS = 8;
  localparam int UW         = 28;
  localparam int ZW         = 35;

  localparam int SEG_RY = 15;
  localparam int SEG_YG = 6;
  localparam int SEG_GC = 4;
  localparam int SEG_CB = 11;
  localparam int SEG_BM = 13;
  localparam int SEG_MR = 6;
  localparam int WHEEL_SIZE = 55;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [ZW-1:0] HALF_TURN = 35'sd2147483648;

  localparam logic [31:0] ATAN_TURNS [CORDIC_MAX_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic                 vld;
    logic signed [UW-1:0] u;
    logic signed [UW-1:0] v;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // wheel entry k as {r, g, b}
  function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
    int kk;
    int i;
    int r;
    int g;
    int b;
    kk = int'(k);
    r = 0;
    g = 0;
    b = 0;
    if (kk < SEG_RY) begin
      r = 255; g = 255 * kk / SEG_RY; b = 0;
    end else if (kk < SEG_RY + SEG_YG) begin
      i = kk - SEG_RY;
      r = 255 - 255 * i / SEG_YG; g = 255; b = 0;
    end else if (kk < SEG_RY + SEG_YG + SEG_GC) begin
      i = kk - (SEG_RY + SEG_YG);
      r = 0; g = 255; b = 255 * i / SEG_GC;
    end else if (kk < SEG_RY + SEG_YG + SEG_GC + SEG_CB) begin
      i = kk - (SEG_RY + SEG_YG + SEG_GC);
      r = 0; g = 255 - 255 * i / SEG_CB; b = 255;
    end else if (kk < SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM) begin
      i = kk - (SEG_RY + SEG_YG + SEG_GC + SEG_CB);
      r = 255 * i / SEG_BM; g = 0; b = 255;
    end else begin
      i = kk - (SEG_RY + SEG_YG + SEG_GC + SEG_CB + SEG_BM);
      if (i >= SEG_MR) i = SEG_MR - 1;
      r = 255; g = 0; b = 255 - 255 * i / SEG_MR;
    end
    return {r[7:0], g[7:0], b[7:0]};
  endfunction

endpackage

/* rtl/fvcc_cordic_cell.sv */
module fvcc_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  fvcc_pkg::cordic_t d_in,
  output fvcc_pkg::cordic_t d_out
);

  localparam logic signed [fvcc_pkg::ZW-1:0] ATAN =
    fvcc_pkg::ZW'(fvcc_pkg::ATAN_TURNS[IDX]);

  fvcc_pkg::cordic_t d_r;
  fvcc_pkg::cordic_t d_nxt;

  logic signed [fvcc_pkg::UW-1:0] us;
  logic signed [fvcc_pkg::UW-1:0] vs;

  always_comb begin
    us = d_in.u >>> IDX;
    vs = d_in.v >>> IDX;
    d_nxt = d_in;
    if (d_in.v < 0) begin
      d_nxt.u = d_in.u - vs;
      d_nxt.v = d_in.v + us;
      d_nxt.z = d_in.z - ATAN;
    end else begin
      d_nxt.u = d_in.u + vs;
      d_nxt.v = d_in.v - us;
      d_nxt.z = d_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.vld <= 1'b0;
    end else begin
      d_r.vld <= d_in.vld;
    end
    d_r.u <= d_nxt.u;
    d_r.v <= d_nxt.v;
    d_r.z <= d_nxt.z;
  end

  assign d_out = d_r;

endmodule

/* rtl/fvcc_color.sv */
module fvcc_color #(
  parameter int FLOW_FRAC_BITS = fvcc_pkg::FLOW_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fvcc_pkg::cordic_t   d_in,
  output logic                out_valid,
  output fvcc_pkg::out_item_t out_data
);

  localparam int PW = fvcc_pkg::UW - 1 + 30;
  localparam int SH = 22 + FLOW_FRAC_BITS;
  localparam logic [32:0] FULL = 33'h1_0000_0000;

  logic [4:0] vld_r;

  // constant wheel, folded at elaboration
  logic [23:0] wheel_tbl [fvcc_pkg::WHEEL_SIZE];

  for (genvar k = 0; k < fvcc_pkg::WHEEL_SIZE; k++) begin : g_wheel
    assign wheel_tbl[k] = fvcc_pkg::wheel_rgb(6'(k));
  end

  // stage A: saturated angle and radius product
  logic [32:0]    t_r;
  logic [PW-1:0]  prod_r;
  logic signed [fvcc_pkg::ZW-1:0] tt;
  logic [32:0]    t_nxt;

  always_comb begin
    tt = d_in.z + fvcc_pkg::HALF_TURN;
    if (tt < 0) t_nxt = '0;
    else if (tt > $signed({2'b0, FULL})) t_nxt = FULL;
    else t_nxt = tt[32:0];
  end

  // stage B: wheel index, fraction, radius range
  logic [38:0] p;
  logic [PW-1:0] rad_full;
  logic [5:0]  k0_nxt;
  logic [5:0]  k0_r;
  logic [5:0]  k1_r;
  logic [11:0] f_r;
  logic        le_r;
  logic [16:0] rad_r;

  always_comb begin
    p = ({6'b0, t_r} << 5) + ({6'b0, t_r} << 4) + ({6'b0, t_r} << 2)
      + ({6'b0, t_r} << 1);
    k0_nxt = (p[38:32] > 7'(fvcc_pkg::WHEEL_SIZE - 1)) ?
             6'(fvcc_pkg::WHEEL_SIZE - 1) : p[37:32];
    rad_full = prod_r >> SH;
  end

  // stage C: wheel lookup; stage D: blend; stage E: saturation mix
  logic [12:0] f_c_r;
  logic        le_c_r;
  logic [16:0] rad_c_r;
  logic [23:0] c0_r;
  logic [23:0] c1_r;
  logic        le_d_r;
  logic [16:0] rad_d_r;
  logic [19:0] bl_r [3];
  logic [19:0] bl_nxt [3];
  logic [7:0]  ch_nxt [3];
  logic [35:0] val [3];
  logic [21:0] dim [3];
  logic [19:0] diff [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      bl_nxt[c] = 20'(13'd4096 - f_c_r) * 20'(c0_r[(2-c)*8 +: 8])
                + 20'(f_c_r) * 20'(c1_r[(2-c)*8 +: 8]);
      diff[c] = 20'd1044480 - bl_r[c];
      val[c]  = {8'd255, 28'd0} - 36'(rad_d_r) * 36'(diff[c]);
      dim[c]  = 22'(bl_r[c]) * 22'd3;
      ch_nxt[c] = le_d_r ? val[c][35:28] : dim[c][21:14];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], d_in.vld};
    end
    t_r    <= t_nxt;
    prod_r <= PW'(d_in.u[fvcc_pkg::UW-2:0]) * PW'(fvcc_pkg::INV_GAIN_Q30);
    k0_r   <= k0_nxt;
    k1_r   <= (k0_nxt == 6'(fvcc_pkg::WHEEL_SIZE - 1)) ? 6'd0 : k0_nxt + 6'd1;
    f_r    <= p[31:20];
    le_r   <= (rad_full <= PW'(65536));
    rad_r  <= rad_full[16:0];
    f_c_r  <= {1'b0, f_r};
    le_c_r <= le_r;
    rad_c_r <= rad_r;
    c0_r   <= wheel_tbl[k0_r];
    c1_r   <= wheel_tbl[k1_r];
    le_d_r <= le_c_r;
    rad_d_r <= rad_c_r;
    for (int c = 0; c < 3; c++) bl_r[c] <= bl_nxt[c];
    out_data <= '{red: ch_nxt[0], green: ch_nxt[1], blue: ch_nxt[2]};
  end

  assign out_valid = vld_r[4];

endmodule

/* rtl/flow_vector_color_coding.sv */
// Channel  Ports                        Handshake
// input    start, busy, in_data         taken when start && !busy
// result   out_valid, out_data          one-cycle strobe, no backpressure
//
// One item per clock. The pipeline is one fold register, one CORDIC cell per
// stage and five color stages, the last of which is the output register.
// busy is never raised; the pipeline has no stall path.
// Reset (rst_n, synchronous) clears only the valid bits of the pipeline.
module flow_vector_color_coding #(
  parameter int FLOW_FRAC_BITS = fvcc_pkg::FLOW_FRAC_BITS_DEF,
  parameter int CORDIC_STAGES  = fvcc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  fvcc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output fvcc_pkg::out_item_t out_data
);

  fvcc_pkg::cordic_t fold_r;
  fvcc_pkg::cordic_t fold_nxt;
  fvcc_pkg::cordic_t chain [CORDIC_STAGES+1];

  logic signed [fvcc_pkg::UW-1:0] xs;
  logic signed [fvcc_pkg::UW-1:0] ys;

  assign busy = 1'b0;

  // fold (-x, -y) into the right half plane
  always_comb begin
    xs = fvcc_pkg::UW'(in_data.flow_x) <<< fvcc_pkg::GUARD_BITS;
    ys = fvcc_pkg::UW'(in_data.flow_y) <<< fvcc_pkg::GUARD_BITS;
    fold_nxt.vld = start;
    if (in_data.flow_x > 0) begin
      fold_nxt.u = xs;
      fold_nxt.v = ys;
      fold_nxt.z = (in_data.flow_y < 0) ? fvcc_pkg::HALF_TURN : -fvcc_pkg::HALF_TURN;
    end else begin
      fold_nxt.u = -xs;
      fold_nxt.v = -ys;
      fold_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r.vld <= 1'b0;
    end else begin
      fold_r.vld <= fold_nxt.vld;
    end
    fold_r.u <= fold_nxt.u;
    fold_r.v <= fold_nxt.v;
    fold_r.z <= fold_nxt.z;
  end

  assign chain[0] = fold_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    fvcc_cordic_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[g]),
      .d_out (chain[g+1])
    );
  end

  fvcc_color #(.FLOW_FRAC_BITS(FLOW_FRAC_BITS)) u_color (
    .clk       (clk),
    .rst_n     (rst_n),
    .d_in      (chain[CORDIC_STAGES]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_flow_vector_color_coding.sv */
module tb_flow_vector_color_coding;

  localparam int FRAC    = 12;
  localparam int STAGES  = 16;
  localparam int LATENCY = STAGES + 6;
  localparam longint CYCLE_LIMIT = 200000;
  localparam longint HALF = 64'sd2147483648;
  localparam longint FULL = 64'sd4294967296;

  // wheel entry k, channel ch (0 red, 1 green, 2 blue)
  function automatic longint wheel_chan(int k, int ch);
    int r, g, b, i;
    if (k < 15) begin
      r = 255; g = 255 * k / 15; b = 0;
    end else if (k < 21) begin
      i = k - 15; r = 255 - 255 * i / 6; g = 255; b = 0;
    end else if (k < 25) begin
      i = k - 21; r = 0; g = 255; b = 255 * i / 4;
    end else if (k < 36) begin
      i = k - 25; r = 0; g = 255 - 255 * i / 11; b = 255;
    end else if (k < 49) begin
      i = k - 36; r = 255 * i / 13; g = 0; b = 255;
    end else begin
      i = k - 49;
      if (i >= 6) i = 5;
      r = 255; g = 0; b = 255 - 255 * i / 6;
    end
    return ch == 0 ? r : (ch == 1 ? g : b);
  endfunction

  // arithmetic shift of a signed longint is a floor shift
  function automatic fvcc_pkg::out_item_t color_of(fvcc_pkg::in_item_t it);
    longint u, v, z, nu, nv, t, p, rad, bl, val;
    int k0, k1, f;
    longint atn [24];
    fvcc_pkg::out_item_t o;
    atn = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
            32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
            32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
    u = -longint'(it.flow_x) * 256;
    v = -longint'(it.flow_y) * 256;
    z = 0;
    if (u < 0) begin
      z = (v > 0) ? HALF : -HALF;
      u = -u;
      v = -v;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (v < 0) begin
        nu = u - (v >>> i); nv = v + (u >>> i); z -= atn[i];
      end else begin
        nu = u + (v >>> i); nv = v - (u >>> i); z += atn[i];
      end
      u = nu;
      v = nv;
    end
    t = z + HALF;
    if (t < 0) t = 0;
    if (t > FULL) t = FULL;
    p = t * 54;
    k0 = int'(p >> 32);
    if (k0 > 54) k0 = 54;
    f = int'((p >> 20) & 64'hFFF);
    k1 = (k0 + 1 >= 55) ? 0 : k0 + 1;
    rad = (u * 652032874) >> (22 + FRAC);
    for (int ch = 0; ch < 3; ch++) begin
      bl = longint'(4096 - f) * wheel_chan(k0, ch) + longint'(f) * wheel_chan(k1, ch);
      if (rad <= 65536) val = (longint'(255) << 28) - rad * (255 * 4096 - bl);
      else val = (3 * bl) << 14;
      val = (val >> 28) & 255;
      if (ch == 0) o.red = val[7:0];
      else if (ch == 1) o.green = val[7:0];
      else o.blue = val[7:0];
    end
    return o;
  endfunction

  class pixel_board;
    fvcc_pkg::out_item_t pending[$];
    int errors;
    int checked;

    function void note_vector(fvcc_pkg::in_item_t it);
      pending.insert(pending.size(), color_of(it));
    endfunction

    function void check_pixel(fvcc_pkg::out_item_t got);
      fvcc_pkg::out_item_t exp_px;
      if (pending.size() == 0) begin
        $error("pixel with no vector outstanding: %h", got);
        errors++;
        return;
      end
      exp_px = pending.pop_front();
      checked++;
      if (got.red !== exp_px.red) begin
        $error("red: expected %0d, got %0d", exp_px.red, got.red); errors++;
      end
      if (got.green !== exp_px.green) begin
        $error("green: expected %0d, got %0d", exp_px.green, got.green); errors++;
      end
      if (got.blue !== exp_px.blue) begin
        $error("blue: expected %0d, got %0d", exp_px.blue, got.blue); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid;
  fvcc_pkg::in_item_t in_data;
  fvcc_pkg::out_item_t out_data;
  pixel_board board;
  longint cycles;
  bit no_gaps;

  flow_vector_color_coding dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    board = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) board.check_pixel(out_data);
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // holds start high until the item is taken; idles at random first
  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y);
    while (!no_gaps && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= '{flow_x: x, flow_y: y};
    do @(posedge clk); while (busy);
    board.note_vector('{flow_x: x, flow_y: y});
  endtask

  function automatic logic signed [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(8192)) - 4096);
      default: return 16'($signed($urandom_range(12000)) - 6000);
    endcase
  endfunction

  initial begin
    int mode;
    no_gaps = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: zero, axes, extremes, unit circle, near half-turn seam
    send_vector(0, 0);
    send_vector(16'sd4096, 0);
    send_vector(-16'sd4096, 0);
    send_vector(0, 16'sd4096);
    send_vector(0, -16'sd4096);
    send_vector(1, 0);
    send_vector(-16'sd32768, -16'sd32768);
    send_vector(16'sd32767, 16'sd32767);
    send_vector(-16'sd32768, 16'sd32767);
    send_vector(16'sd32767, -16'sd32768);
    send_vector(-16'sd32768, 0);
    send_vector(0, -16'sd32768);
    send_vector(-16'sd4096, 1);
    send_vector(-16'sd4096, -1);
    send_vector(16'sd2896, 16'sd2896);
    send_vector(-16'sd2896, 16'sd2896);
    send_vector(16'sd2048, -16'sd1000);
    send_vector(16'sd4097, 0);
    send_vector(-16'sd1, -16'sd1);
    send_vector(16'sd3000, 16'sd2000);
    for (int n = 0; n < 1030; n++) begin
      no_gaps = (n >= 400 && n < 600);
      mode = $urandom_range(2);
      send_vector(rand_comp(mode), rand_comp(mode));
    end
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    $display("Covered %0d pixels: axes, extremes, unit circle, inside and outside radius 1.",
             board.checked);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
